@@ rtl/lcr_pkg.sv @@
// Shared constants and widths for the per-line circular rotate block.
package lcr_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = COL_W + 1;
    localparam int DEPTH     = 2 * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PIX_W     = 32;
    localparam int SKEW_W    = 16;
    localparam int DIV_CNT_W = $clog2(SKEW_W + 1);

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [WID_W-1:0]  t_width;
    typedef logic [ADDR_W-1:0] t_addr;

endpackage

@@ rtl/line_circular_rotate.sv @@
// Per-line circular horizontal rotate of a 32-bit pixel stream over a ping-pong line store.
//
// Input channel i_in_valid/o_in_ready carries one pixel per request plus the
// line skew, which is sampled only at column 0. Output channel
// o_out_valid/i_out_ready returns the rotated previous line, one pixel per
// request, with its column and an end-of-line flag. Output lags input by one
// line; push a filler line to drain the last one.
// Throughput: one pixel per cycle inside a line while the output is not
// stalled. At column 0 the skew is reduced modulo the line width by a 16-step
// restoring divider before the first pixel of the line is taken. A width write
// in the middle of a line re-reduces the stored shift the same way.
// A result is read from the line store into the read stage when its request is
// taken, and then moves on to the output register.
// The line store is one 8192 x 32 memory, one write and one read port.
// Reset clears counters, bank select and the line-ready flag; the store is not
// cleared and no result is produced until one full line has been written.
// When the receiver stalls, one result waits in the output register and one in
// the read stage; the input stalls only once both are full.
// i_cfg_we writes line_width at any edge; write it only while idle.
module line_circular_rotate (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [12:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lcr_pkg::t_pixel        i_pixel_in,
    input  logic signed [15:0]     i_line_skew,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lcr_pkg::t_pixel        o_pixel_out,
    output lcr_pkg::t_col          o_out_column,
    output logic                   o_last_in_line
);
    import lcr_pkg::*;

    localparam logic [1:0] S_RUN = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_FIX = 2'd2;

    logic [12:0]           r_cfg_width;
    logic [1:0]            r_state;
    logic                  r_shift_ok;
    logic                  r_reduce;
    t_col                  r_shift;
    t_col                  r_col;
    logic                  r_bank;
    logic                  r_line_ready;

    t_width                r_div_rem;
    logic [SKEW_W-1:0]     r_div_mag;
    logic                  r_div_neg;
    logic                  r_div_sel;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    t_pixel                mem [0:DEPTH-1];
    t_pixel                r_rdata;
    logic                  r_p1_valid;
    t_col                  r_p1_col;
    logic                  r_p1_last;

    logic                  r_out_valid;
    t_pixel                r_out_pixel;
    t_col                  r_out_col;
    logic                  r_out_last;

    t_width                w;
    t_width                wm1;
    t_col                  c_eff;
    logic                  last;
    logic                  accept;
    logic                  adv;
    logic                  div_start;
    logic                  red_start;
    logic [WID_W:0]        trial;
    t_width                n_div_rem;
    t_width                fix_val;
    t_width                dsum;
    t_col                  dest;
    t_addr                 waddr;
    t_addr                 raddr;
    logic [SKEW_W-1:0]     skew_mag;

    always_comb begin
        if (r_cfg_width == '0) begin
            w = t_width'(1);
        end else if ({1'b0, r_cfg_width} > (WID_W + 1)'(MAX_WIDTH)) begin
            w = t_width'(MAX_WIDTH);
        end else begin
            w = t_width'(r_cfg_width);
        end
        wm1 = w - t_width'(1);
        if ({1'b0, r_col} >= w) begin
            c_eff = wm1[COL_W-1:0];
        end else begin
            c_eff = r_col;
        end
        last = ({1'b0, c_eff} == wm1);
    end

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN) && ((c_eff == '0) ? r_shift_ok : !r_reduce)
                        && (!r_p1_valid || adv);
    assign accept     = i_in_valid && o_in_ready;
    assign div_start  = (r_state == S_RUN) && i_in_valid && c_eff == '0 && !r_shift_ok;
    assign red_start  = (r_state == S_RUN) && c_eff != '0 && r_reduce;

    assign skew_mag = i_line_skew[SKEW_W-1] ? (~i_line_skew + 1'b1) : i_line_skew;

    always_comb begin
        trial = {r_div_rem, r_div_mag[SKEW_W-1]};
        if (trial >= {1'b0, w}) begin
            n_div_rem = t_width'(trial - {1'b0, w});
        end else begin
            n_div_rem = t_width'(trial);
        end
        if (r_div_neg && r_div_rem != '0) begin
            fix_val = w - r_div_rem;
        end else begin
            fix_val = r_div_rem;
        end
    end

    always_comb begin
        dsum = {1'b0, c_eff} + {1'b0, r_shift};
        if (dsum >= w) begin
            dsum = dsum - w;
        end
        dest  = dsum[COL_W-1:0];
        waddr = r_bank ? (t_addr'(MAX_WIDTH) + t_addr'(dest)) : t_addr'(dest);
        raddr = r_bank ? t_addr'(c_eff) : (t_addr'(MAX_WIDTH) + t_addr'(c_eff));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[waddr] <= i_pixel_in;
            r_rdata    <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_col  <= c_eff;
            r_p1_last <= last;
        end
        if (r_p1_valid && adv) begin
            r_out_pixel <= r_rdata;
            r_out_col   <= r_p1_col;
            r_out_last  <= r_p1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 13'(MAX_WIDTH);
            r_state      <= S_RUN;
            r_shift_ok   <= 1'b0;
            r_reduce     <= 1'b0;
            r_shift      <= '0;
            r_col        <= '0;
            r_bank       <= 1'b0;
            r_line_ready <= 1'b0;
            r_div_rem    <= '0;
            r_div_mag    <= '0;
            r_div_neg    <= 1'b0;
            r_div_sel    <= 1'b0;
            r_div_cnt    <= '0;
            r_p1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_width <= i_cfg_data;
            end

            unique case (r_state)
                S_RUN: begin
                    if (div_start && !i_cfg_we) begin
                        r_state   <= S_DIV;
                        r_div_rem <= '0;
                        r_div_mag <= skew_mag;
                        r_div_neg <= i_line_skew[SKEW_W-1];
                        r_div_sel <= 1'b0;
                        r_div_cnt <= '0;
                    end else if (red_start && !i_cfg_we) begin
                        // width changed mid-line: bring the stored shift below it
                        r_state   <= S_DIV;
                        r_div_rem <= '0;
                        r_div_mag <= {{(SKEW_W - COL_W){1'b0}}, r_shift};
                        r_div_neg <= 1'b0;
                        r_div_sel <= 1'b1;
                        r_div_cnt <= '0;
                    end
                end
                S_DIV: begin
                    r_div_rem <= n_div_rem;
                    r_div_mag <= {r_div_mag[SKEW_W-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(SKEW_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (!i_cfg_we) begin
                        r_shift <= fix_val[COL_W-1:0];
                    end
                    if (r_div_sel) begin
                        r_reduce <= 1'b0;
                    end else begin
                        r_shift_ok <= 1'b1;
                    end
                    r_state <= S_RUN;
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase

            if (i_cfg_we) begin
                r_state    <= S_RUN;
                r_shift_ok <= 1'b0;
                r_reduce   <= 1'b1;
            end

            if (accept) begin
                if (c_eff == '0) begin
                    r_shift_ok <= 1'b0;
                    r_reduce   <= 1'b0;
                end
                if (last) begin
                    r_col        <= '0;
                    r_bank       <= ~r_bank;
                    r_line_ready <= 1'b1;
                end else begin
                    r_col <= c_eff + 1'b1;
                end
            end

            if (accept) begin
                r_p1_valid <= r_line_ready;
            end else if (adv) begin
                r_p1_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_out_pixel;
    assign o_out_column   = r_out_col;
    assign o_last_in_line = r_out_last;

    a_ready_needs_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && c_eff == '0) |-> (r_shift_ok && r_state == S_RUN))
        else $error("input taken at column 0 without a reduced shift");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_ok |-> ({1'b0, r_shift} < w))
        else $error("reduced shift not below line width");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_col)))
        else $error("stalled result dropped or changed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !adv) |-> !accept)
        else $error("read stage overwritten while stalled");

endmodule

@@ tb/line_circular_rotate_test.sv @@
// Self-checking testbench for line_circular_rotate: random line streams checked against a rotating line store.
module line_circular_rotate_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcr_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_CAP     = 200;

    typedef struct {
        t_pixel            pix;
        logic signed [15:0] skew;
    } t_source;

    typedef struct {
        t_pixel pix;
        t_col   col;
        logic   last;
    } t_rotated;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [12:0]        cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    t_pixel             pixel_in    = '0;
    logic signed [15:0] line_skew   = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    t_pixel             pixel_out;
    t_col               out_column;
    logic               last_in_line;

    line_circular_rotate dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_pixel_in     (pixel_in),
        .i_line_skew    (line_skew),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_out    (pixel_out),
        .o_out_column   (out_column),
        .o_last_in_line (last_in_line)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the block
    t_pixel      line_copy [0:2*MAX_WIDTH-1];
    int          next_col    = 0;
    bit          fill_bank   = 1'b0;
    int          line_shift  = 0;
    bit          line_held   = 1'b0;
    logic [12:0] width_reg   = 13'd4096;

    t_source  source_q[$];
    t_rotated rotated_q[$];
    int       source_left    = 0;
    int       mismatches     = 0;
    int       quiet_cycles   = 0;
    int       send_gap_pct   = 0;
    int       recv_stall_pct = 0;

    function automatic int eff_width(logic [12:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    task automatic rotate_predict(t_pixel pix, logic signed [15:0] skew);
        int       w;
        int       c;
        int       r;
        bit       last;
        t_rotated e;
        w = eff_width(width_reg);
        c = (next_col >= w) ? w - 1 : next_col;
        last = (c == w - 1);
        if (c == 0) begin
            r = int'(skew) % w;
            if (r < 0)
                r += w;
            line_shift = r;
        end
        if (line_held) begin
            e.pix  = line_copy[(fill_bank ? 0 : MAX_WIDTH) + c];
            e.col  = t_col'(c);
            e.last = last;
            rotated_q.push_back(e);
        end
        line_copy[(fill_bank ? MAX_WIDTH : 0) + (c + line_shift) % w] = pix;
        if (last) begin
            next_col  = 0;
            fill_bank = ~fill_bank;
            line_held = 1'b1;
        end else begin
            next_col = c + 1;
        end
    endtask

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // request driver
    always @(posedge clk) begin
        t_source nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                rotate_predict(pixel_in, line_skew);
                source_left--;
            end
            if (!in_valid || in_ready) begin
                if (source_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = source_q.pop_front();
                    in_valid  <= 1'b1;
                    pixel_in  <= nxt.pix;
                    line_skew <= nxt.skew;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_rotated e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (rotated_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected pixel %h at column %0d",
                                            pixel_out, out_column));
                end else begin
                    e = rotated_q.pop_front();
                    if (pixel_out !== e.pix)
                        flag_mismatch($sformatf("column %0d pixel %h, want %h",
                                                e.col, pixel_out, e.pix));
                    if (out_column !== e.col)
                        flag_mismatch($sformatf("column %0d, want %0d", out_column, e.col));
                    if (last_in_line !== e.last)
                        flag_mismatch($sformatf("column %0d end of line %b, want %b",
                                                e.col, last_in_line, e.last));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no input or output handshake and no width write
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TIMEOUT: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pixel(t_pixel pix, logic signed [15:0] skew);
        t_source s;
        s.pix  = pix;
        s.skew = skew;
        source_q.push_back(s);
        source_left++;
    endtask

    function automatic t_pixel pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_skew(int w);
        int v;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1:       v = int'($urandom_range(0, 4 * w)) - 2 * w;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return 16'(v);
    endfunction

    task automatic push_run(int n, int w);
        repeat (n) push_pixel(pick_pixel(), pick_skew(w));
    endtask

    task automatic settle();
        while (source_left != 0 || rotated_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(logic [12:0] w);
        settle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg  = w;
    endtask

    function automatic logic [12:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 13'($urandom_range(1, 8));
        if (r < 85)
            return 13'($urandom_range(9, 40));
        if (r < 98)
            return 13'($urandom_range(41, 120));
        return 13'($urandom_range(121, 200));
    endfunction

    task automatic random_lines(int count);
        int          pushed;
        int          w;
        int          k;
        logic [12:0] w2;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(99) < 30)
                set_width(pick_width());
            w = eff_width(width_reg);
            if (w > 1 && $urandom_range(99) < 6) begin
                // stop mid-line, then retarget the width
                k = $urandom_range(1, w - 1);
                push_run(k, w);
                w2 = ($urandom_range(1)) ? 13'($urandom_range(1, k)) : pick_width();
                set_width(w2);
                w = eff_width(w2);
                push_run((k >= w) ? 1 : w - k, w);
                pushed += k + ((k >= w) ? 1 : w - k);
            end else begin
                push_run(w, w);
                pushed += w;
            end
        end
    endtask

    initial begin
        foreach (line_copy[i])
            line_copy[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct   = 9;
        recv_stall_pct = 78;

        // two lines at the widest random width so both banks hold data
        set_width(13'd200);
        push_pixel('0, 16'sh8000);
        push_pixel('1, 16'sd32767);
        push_run(198, 200);
        push_pixel('1, -16'sd1);
        push_run(199, 200);

        // width above MAX_WIDTH, then shrunk below the current column
        set_width(13'd8191);
        push_pixel(32'h0f0f_f0f0, 16'sd32767);
        push_run(4, MAX_WIDTH);
        set_width(13'd3);
        push_pixel(32'hcafe_f00d, 16'sd0);
        set_width(13'd4096);
        push_pixel(32'h3c3c_c3c3, 16'sh8000);
        push_run(2, MAX_WIDTH);
        set_width(13'd2);
        push_pixel(32'hc3c3_3c3c, 16'sd1);

        set_width(13'd1);
        push_pixel('0, 16'sh8000);
        push_pixel('1, 16'sd32767);
        push_pixel(32'h5a5a_a5a5, 16'sd0);
        push_pixel(32'ha5a5_5a5a, -16'sd1);
        set_width(13'd0);
        push_pixel(32'h0123_4567, 16'sd5);
        push_pixel(32'h89ab_cdef, -16'sd5);
        set_width(13'd2);
        push_pixel('1, -16'sd1);
        push_pixel('0, 16'sd0);
        push_pixel(32'h8000_0001, 16'sh8000);
        push_pixel(32'h7fff_fffe, 16'sd0);
        set_width(13'd3);
        push_pixel(32'h1111_1111, -16'sd4);
        push_run(2, 3);
        push_pixel(32'h2222_2222, 16'sd7);
        push_run(2, 3);
        // width shrinks below the current column mid-line
        set_width(13'd5);
        push_run(3, 5);
        set_width(13'd2);
        push_pixel(32'hdead_beef, 16'sd0);
        // width grows mid-line
        set_width(13'd4);
        push_run(2, 4);
        set_width(13'd7);
        push_run(5, 7);

        random_lines(120);
        settle();
        send_gap_pct   = 78;
        recv_stall_pct = 9;
        random_lines(120);
        settle();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_lines(120);

        settle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
